// ===== rtl/core/ipv4ddp_pkg.sv =====
package ipv4ddp_pkg;

    // Parser phases; codes above PH_DONE are never reached.
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_START  = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MALFORM  = 2'd1;
    localparam logic [1:0] ST_TOOLARGE = 2'd2;

    // Character constants.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [11:0] PART_MAX   = 12'd255;
    localparam logic [1:0]  LAST_PART  = 2'd3;
    localparam logic [31:0] ADDR_ERROR = 32'hFFFF_FFFF;

    // Complete parser state.
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  part_index;
        logic [7:0]  part_acc;
        logic [31:0] address;
        logic [1:0]  error_code;
    } parse_state_t;

    // One finished result handed from the parser to the output register.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } parse_result_t;

endpackage

// ===== rtl/core/ipv4ddp_core.sv =====
module ipv4ddp_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic [7:0]                 char_in,
    input  logic                       last_char,
    output ipv4ddp_pkg::parse_result_t result
);

    ipv4ddp_pkg::parse_state_t state_reg;
    ipv4ddp_pkg::parse_state_t state_next;
    ipv4ddp_pkg::parse_state_t taken;
    ipv4ddp_pkg::parse_state_t ended;

    function automatic logic is_space(input logic [7:0] c);
        return (c == ipv4ddp_pkg::CH_SPACE) || (c == ipv4ddp_pkg::CH_TAB) ||
               (c == ipv4ddp_pkg::CH_CR) || (c == ipv4ddp_pkg::CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ipv4ddp_pkg::CH_ZERO) && (c <= ipv4ddp_pkg::CH_NINE);
    endfunction

    // Merge the current part into its byte lane of the address.
    function automatic logic [31:0] commit(input ipv4ddp_pkg::parse_state_t s);
        return s.address | ({24'd0, s.part_acc} << {s.part_index, 3'b000});
    endfunction

    // Judge the text as ended at the current position.
    function automatic ipv4ddp_pkg::parse_state_t end_text(
        input ipv4ddp_pkg::parse_state_t s);
        ipv4ddp_pkg::parse_state_t r;
        r = s;
        case (s.phase)
            ipv4ddp_pkg::PH_DIGITS:
            begin
                if (s.part_index == ipv4ddp_pkg::LAST_PART)
                begin
                    r.address = commit(s);
                end
                else
                begin
                    r.error_code = ipv4ddp_pkg::ST_MALFORM;
                end
                r.phase = ipv4ddp_pkg::PH_DONE;
            end
            ipv4ddp_pkg::PH_TRAIL:
            begin
                r.phase = ipv4ddp_pkg::PH_DONE;
            end
            ipv4ddp_pkg::PH_DONE:
            begin
                r = s;
            end
            default:
            begin
                r.error_code = ipv4ddp_pkg::ST_MALFORM;
                r.phase      = ipv4ddp_pkg::PH_DONE;
            end
        endcase
        return r;
    endfunction

    // Apply one character to the state.
    function automatic ipv4ddp_pkg::parse_state_t take_char(
        input ipv4ddp_pkg::parse_state_t s, input logic [7:0] c);
        ipv4ddp_pkg::parse_state_t r;
        logic [11:0]               val;
        logic [7:0]                digit;
        r     = s;
        digit = c - ipv4ddp_pkg::CH_ZERO;
        val   = ({4'd0, s.part_acc} << 3) + ({4'd0, s.part_acc} << 1) + {4'd0, digit};
        if (s.phase == ipv4ddp_pkg::PH_DONE)
        begin
            r = s;
        end
        else if (c == ipv4ddp_pkg::CH_NUL)
        begin
            r = end_text(s);
        end
        else
        begin
            case (s.phase)
                ipv4ddp_pkg::PH_LEAD, ipv4ddp_pkg::PH_START:
                begin
                    if ((s.phase == ipv4ddp_pkg::PH_LEAD) && is_space(c))
                    begin
                        r = s;
                    end
                    else if (is_digit(c))
                    begin
                        r.part_acc = digit;
                        r.phase    = ipv4ddp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        r.error_code = ipv4ddp_pkg::ST_MALFORM;
                        r.phase      = ipv4ddp_pkg::PH_DONE;
                    end
                end
                ipv4ddp_pkg::PH_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        if (val > ipv4ddp_pkg::PART_MAX)
                        begin
                            r.error_code = ipv4ddp_pkg::ST_TOOLARGE;
                            r.phase      = ipv4ddp_pkg::PH_DONE;
                        end
                        else
                        begin
                            r.part_acc = val[7:0];
                        end
                    end
                    else if ((c == ipv4ddp_pkg::CH_DOT) &&
                             (s.part_index != ipv4ddp_pkg::LAST_PART))
                    begin
                        r.address    = commit(s);
                        r.part_index = s.part_index + 2'd1;
                        r.part_acc   = 8'd0;
                        r.phase      = ipv4ddp_pkg::PH_START;
                    end
                    else if (is_space(c) && (s.part_index == ipv4ddp_pkg::LAST_PART))
                    begin
                        r.address = commit(s);
                        r.phase   = ipv4ddp_pkg::PH_TRAIL;
                    end
                    else
                    begin
                        r.error_code = ipv4ddp_pkg::ST_MALFORM;
                        r.phase      = ipv4ddp_pkg::PH_DONE;
                    end
                end
                ipv4ddp_pkg::PH_TRAIL:
                begin
                    if (!is_space(c))
                    begin
                        r.error_code = ipv4ddp_pkg::ST_MALFORM;
                        r.phase      = ipv4ddp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    r.error_code = ipv4ddp_pkg::ST_MALFORM;
                    r.phase      = ipv4ddp_pkg::PH_DONE;
                end
            endcase
        end
        return r;
    endfunction

    // Next state: apply the character, and restart after the last one.
    always_comb
    begin
        taken      = take_char(state_reg, char_in);
        ended      = end_text(taken);
        state_next = state_reg;
        if (step_en)
        begin
            if (last_char)
            begin
                state_next.phase      = ipv4ddp_pkg::PH_LEAD;
                state_next.part_index = 2'd0;
                state_next.part_acc   = 8'd0;
                state_next.address    = 32'd0;
                state_next.error_code = ipv4ddp_pkg::ST_OK;
            end
            else
            begin
                state_next = taken;
            end
        end
    end

    // Result of the text as judged after this character.
    always_comb
    begin
        result.status  = ended.error_code;
        result.address = (ended.error_code != ipv4ddp_pkg::ST_OK) ?
                         ipv4ddp_pkg::ADDR_ERROR : ended.address;
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= ipv4ddp_pkg::PH_LEAD;
            state_reg.part_index <= 2'd0;
            state_reg.part_acc   <= 8'd0;
            state_reg.address    <= 32'd0;
            state_reg.error_code <= ipv4ddp_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A failed text is always finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.error_code != ipv4ddp_pkg::ST_OK) |->
        (state_reg.phase == ipv4ddp_pkg::PH_DONE))
        else $error("error recorded outside the finished phase");

    // The last word of a text returns the parser to its start state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && last_char) |=>
        (state_reg.phase == ipv4ddp_pkg::PH_LEAD) && (state_reg.part_index == 2'd0) &&
        (state_reg.address == 32'd0) && (state_reg.error_code == ipv4ddp_pkg::ST_OK))
        else $error("parser not restarted after last word");

    // The error code never takes the unused value.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_code != 2'd3)
        else $error("invalid error code");

endmodule

// ===== rtl/core/ipv4_dotted_decimal_parser.sv =====
// Strict dotted-decimal IPv4 parser, one text character per word.
// A result appears on out_valid at the edge where the last word leaves the input register.
// Throughput: one word per cycle; a last word waits in the input register only
// while the previous result is stalled at the output.
// Reset (rst_n, asynchronous, active low) empties both registers and puts the
// parser in its leading-whitespace phase.
module ipv4_dotted_decimal_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] address
);

    logic                       in_full_reg;
    logic                       in_full_next;
    logic [7:0]                 in_char_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 out_status_reg;
    logic [31:0]                out_address_reg;
    logic                       out_free;
    logic                       consume;
    logic                       in_accept;
    ipv4ddp_pkg::parse_result_t result;

    // A word leaves the input register unless it is a last word facing a stalled full output.
    assign out_free  = !out_valid_reg || !out_stall;
    assign consume   = in_full_reg && (!in_last_reg || out_free);
    assign in_stall  = in_full_reg && !consume;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign address   = out_address_reg;

    ipv4ddp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (consume),
        .char_in   (in_char_reg),
        .last_char (in_last_reg),
        .result    (result)
    );

    // Occupancy of the input and output registers.
    always_comb
    begin
        in_full_next = in_accept ? 1'b1 : (consume ? 1'b0 : in_full_reg);
        if (consume && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_char_reg <= char_in;
            in_last_reg <= last_char;
        end
        if (consume && in_last_reg)
        begin
            out_status_reg  <= result.status;
            out_address_reg <= result.address;
        end
    end

    // Input backs up only behind a held last word and a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && in_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

    // A failed result carries the all-ones address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ipv4ddp_pkg::ST_OK)) |->
        (out_address_reg == ipv4ddp_pkg::ADDR_ERROR))
        else $error("failed result without all-ones address");

    // A result is loaded whenever a last word is consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> out_valid_reg)
        else $error("result lost after last word");

endmodule
